FILE: hw/rtl/adcq_pkg.sv
// Shared types and constants for the conversion request queue.
package adcq_pkg;

    typedef enum logic
    {
        CMD_REQUEST  = 1'b0,
        CMD_COMPLETE = 1'b1
    } adcq_cmd_t;

    localparam int unsigned CHANNEL_W   = 4;
    localparam int unsigned SAMPLE_W    = 10;
    localparam int unsigned SLOT_W      = 3;
    localparam int unsigned REF_W       = 2;
    localparam logic [REF_W-1:0] REF_RESET = 2'd1;

    // Result of one item after the pointer stage; the multiplexer channel of a
    // start that follows a completion comes from the store's registered read.
    typedef struct packed
    {
        logic                 accepted;
        logic [SLOT_W-1:0]    request_slot;
        logic                 start_conversion;
        logic                 start_from_store;
        logic [CHANNEL_W-1:0] channel;
        logic                 done_valid;
        logic [SLOT_W-1:0]    done_slot;
        logic [SAMPLE_W-1:0]  done_value;
        logic                 irq_enable;
    } adcq_mid_t;

endpackage

FILE: hw/rtl/adc_conversion_request_queue.sv
// Top level of the conversion request queue: handshakes, config and result register.
// A transaction's result is registered in the first result stage, then in the result register.
// Throughput: one transaction per cycle while the output is not stalled; pointers
// update at acceptance and the channel store's registered read supplies the next channel.
// Reset (rst_n, asynchronous): queue empty, interrupt disabled, both result
// stages empty, reference select back to REF_RESET. No clearing pass is needed.
module adc_conversion_request_queue
    import adcq_pkg::*;
#(
    parameter int unsigned QUEUE_SLOTS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [CHANNEL_W-1:0] channel,
    input  logic [SAMPLE_W-1:0]  sample_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 accepted,
    output logic [SLOT_W-1:0]    request_slot,
    output logic                 start_conversion,
    output logic [CHANNEL_W-1:0] mux_channel,
    output logic                 done_valid,
    output logic [SLOT_W-1:0]    done_slot,
    output logic [SAMPLE_W-1:0]  done_value,
    output logic                 irq_enable,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REF_W-1:0]     cfg_data
);

    localparam int unsigned PTR_W = $clog2(QUEUE_SLOTS);

    logic                 take;
    logic                 mid_take;
    logic                 mid_valid;
    adcq_mid_t            mid;
    logic                 wr_en;
    logic [PTR_W-1:0]     wr_addr;
    logic [PTR_W-1:0]     rd_addr;
    logic [CHANNEL_W-1:0] rd_data;
    logic                 out_free;

    logic                 out_valid_reg, out_valid_next;
    adcq_mid_t            out_reg, out_next;
    logic [REF_W-1:0]     ref_sel_reg, ref_sel_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign mid_take = mid_valid && out_free;
    assign in_stall = mid_valid && !out_free;
    assign take     = in_valid && !in_stall;

    adcq_ctrl #(
        .SLOTS (QUEUE_SLOTS),
        .PTR_W (PTR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .cmd          (cmd),
        .channel      (channel),
        .sample_value (sample_value),
        .mid_take     (mid_take),
        .mid_valid    (mid_valid),
        .mid          (mid),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    adcq_store #(
        .SLOTS (QUEUE_SLOTS),
        .PTR_W (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (channel),
        .rd_en   (take),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_next = mid;
        if (mid.start_from_store)
        begin
            out_next.channel = rd_data;
        end
        out_valid_next = out_valid_reg;
        if (mid_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // The reference select is held in a register and has no effect on any
    // result field.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        ref_sel_next = ref_sel_reg;
        if (cfg_valid && cfg_ready)
        begin
            ref_sel_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ref_sel_reg   <= REF_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            ref_sel_reg   <= ref_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_take)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = out_reg.accepted;
    assign request_slot     = out_reg.request_slot;
    assign start_conversion = out_reg.start_conversion;
    assign mux_channel      = out_reg.channel;
    assign done_valid       = out_reg.done_valid;
    assign done_slot        = out_reg.done_slot;
    assign done_value       = out_reg.done_value;
    assign irq_enable       = out_reg.irq_enable;

    // A result waiting at the output holds the middle stage and the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && mid_valid) |-> in_stall)
        else $error("input taken while both result stages are blocked");

    // A stalled result transaction keeps its stage occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result transaction was dropped");

    // Reported multiplexer channels only accompany a conversion start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !start_conversion) |-> mux_channel == '0)
        else $error("multiplexer channel reported without a start");

endmodule

FILE: hw/rtl/adcq_store.sv
// Channel store: one write port and one registered read port.
module adcq_store
    import adcq_pkg::*;
#(
    parameter int unsigned SLOTS = 8,
    parameter int unsigned PTR_W = 3
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [PTR_W-1:0]     wr_addr,
    input  logic [CHANNEL_W-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [PTR_W-1:0]     rd_addr,
    output logic [CHANNEL_W-1:0] rd_data
);

    logic [CHANNEL_W-1:0] mem [SLOTS];
    logic [CHANNEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/adcq_ctrl.sv
// Head and tail pointers, interrupt enable and the first result stage.
module adcq_ctrl
    import adcq_pkg::*;
#(
    parameter int unsigned SLOTS = 8,
    parameter int unsigned PTR_W = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic                 cmd,
    input  logic [CHANNEL_W-1:0] channel,
    input  logic [SAMPLE_W-1:0]  sample_value,
    input  logic                 mid_take,
    output logic                 mid_valid,
    output adcq_mid_t            mid,
    output logic                 wr_en,
    output logic [PTR_W-1:0]     wr_addr,
    output logic [PTR_W-1:0]     rd_addr
);

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             irq_reg, irq_next;
    logic             mid_valid_reg, mid_valid_next;
    adcq_mid_t        mid_reg, mid_next;

    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;
    logic             empty;

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + PTR_W'(1);
    assign empty    = (head_reg == tail_reg);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        irq_next  = irq_reg;
        wr_en     = 1'b0;
        mid_next  = '0;
        if (take)
        begin
            if (cmd == CMD_REQUEST)
            begin
                if (head_inc != tail_reg)
                begin
                    wr_en                 = 1'b1;
                    head_next             = head_inc;
                    mid_next.accepted     = 1'b1;
                    mid_next.request_slot = SLOT_W'(head_reg);
                    if (empty)
                    begin
                        // The stored channel is the one arriving now.
                        irq_next                  = 1'b1;
                        mid_next.start_conversion = 1'b1;
                        mid_next.channel          = channel;
                    end
                end
            end
            else if (!empty)
            begin
                tail_next           = tail_inc;
                mid_next.done_valid = 1'b1;
                mid_next.done_slot  = SLOT_W'(tail_reg);
                mid_next.done_value = sample_value;
                if (head_reg == tail_inc)
                begin
                    irq_next = 1'b0;
                end
                else
                begin
                    mid_next.start_conversion = 1'b1;
                    mid_next.start_from_store = 1'b1;
                end
            end
        end
        mid_next.irq_enable = irq_next;
    end

    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        if (take)
        begin
            mid_valid_next = 1'b1;
        end
        else if (mid_take)
        begin
            mid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            irq_reg       <= 1'b0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            irq_reg       <= irq_next;
            mid_valid_reg <= mid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mid_reg <= mid_next;
        end
    end

    assign wr_addr   = head_reg;
    assign rd_addr   = tail_next;
    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

    // The interrupt enable tracks a non-empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) irq_reg == (head_reg != tail_reg))
        else $error("interrupt enable disagrees with queue occupancy");

    // An item is either a stored request or a reported completion, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg |-> !(mid_reg.accepted && mid_reg.done_valid))
        else $error("request and completion reported together");

    // A completion always moves the tail by exactly one slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd == CMD_COMPLETE && !empty) |=> tail_reg == $past(tail_inc))
        else $error("tail pointer did not advance on completion");

    // A conversion start never leaves the interrupt disabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && mid_reg.start_conversion) |-> mid_reg.irq_enable)
        else $error("conversion started with interrupt disabled");

endmodule
